// ===== rtl/position_keyed_lzss_decoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the position-keyed LZSS decoder
// ----------------------------------------------------------------------------
`ifndef POSITION_KEYED_LZSS_DECODER_UNIT_MACROS_SVH
`define POSITION_KEYED_LZSS_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define PKLD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define PKLD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pkld_pkg.sv =====
// ----------------------------------------------------------------------------
// pkld_pkg
// Shared constants and controller/datapath interface types for the
// position-keyed LZSS decoder.
// ----------------------------------------------------------------------------
package pkld_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int FILL_W     = RING_AW + 1;

    localparam logic [RING_AW-1:0] START_POS = 12'hFEE;
    localparam logic [7:0]         FILL_BYTE = 8'h20;
    localparam logic [4:0]         MIN_LEN   = 5'd3;
    localparam logic [31:0]        SIZE_RST  = 32'hFFFF_FFFF;

    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_TOK  = 2'd1;
    localparam logic [1:0] PH_B1   = 2'd2;

    localparam logic [3:0] IDX_EMPTY = 4'd8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;        // latch and decrypt the accepted byte
        logic load_flag;   // decrypted byte becomes the flag byte
        logic store_low;   // hold low byte of a back-reference
        logic start_copy;  // set up copy address and length
        logic rd;          // read the ring at the copy address
        logic emit_lit;    // emit the decrypted byte
        logic emit_copy;   // emit the byte read from the ring
        logic advance;     // step to the next flag bit
        logic finish;      // end of item; stream reset on last
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic active;      // output count still below expected size
        logic want_flag;   // next byte is a flag byte
        logic phase_b1;    // next byte is the second byte of a reference
        logic flag_bit;    // current flag bit
        logic out_free;    // output register can take a byte
        logic copy_stop;   // this copy byte is the final one
    } status_t;

endpackage

// ===== rtl/position_keyed_lzss_decoder_unit.sv =====
// Decodes a position-keyed, LZSS-compressed body one request at a time: each
// byte is decrypted by subtracting the low eight bits of its body position,
// then parsed as flag bytes, literals and two-byte back-references into a
// 4096-byte history ring. Each byte of a reference copy of length L (3 to 18)
// takes one ring read and then one write-and-emit on the single ring memory;
// the copy ends early when the size limit is reached, and a stall on the
// result side holds a literal or copy byte until the output register is free.
// There is no clearing pass after reset or after the last byte of a body: a
// fill count marks which ring entries have been written, and unwritten entries
// read as 0x20.
// ----------------------------------------------------------------------------
// position_keyed_lzss_decoder_unit
// Top level: controller, datapath and assertions.
// ----------------------------------------------------------------------------
`include "position_keyed_lzss_decoder_unit_macros.svh"

module position_keyed_lzss_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,   // expected_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] out_byte
    output logic        m_tlast,
    output logic        m_tuser      // [0] out_done
);

    pkld_pkg::cmd_t    cmd;
    pkld_pkg::status_t status;

    pkld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pkld_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // A byte is emitted only into a free output register
    `PKLD_ASSERT_IMP(a_emit_slot_free, aclk, aresetn, (cmd.emit_lit || cmd.emit_copy), (status.out_free), "emit into occupied output register")
    // One request in flight at a time
    `PKLD_ASSERT_NXT(a_one_request, aclk, aresetn, (s_tvalid && s_tready), (!s_tready), "second request taken while busy")
    // Token state changes by at most one cause per cycle
    `PKLD_ASSERT_IMP(a_token_update, aclk, aresetn, (1'b1), ($onehot0({cmd.load_flag, cmd.store_low, cmd.start_copy, cmd.emit_lit})), "conflicting token updates")

endmodule

// ===== rtl/pkld_ctrl.sv =====
// ----------------------------------------------------------------------------
// pkld_ctrl
// Sequencer for the decoder: takes one request, parses it and walks a
// back-reference copy one ring read and one emit at a time.
// ----------------------------------------------------------------------------
module pkld_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  pkld_pkg::status_t status,
    output pkld_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PARSE  = 6'b000010,
        ST_LIT    = 6'b000100,
        ST_RD     = 6'b001000,
        ST_WR     = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_PARSE;
                end
            end
            ST_PARSE: begin
                if (!status.active) begin
                    state_next = ST_FINISH;
                end else if (status.want_flag) begin
                    cmd.load_flag = 1'b1;
                    state_next    = ST_FINISH;
                end else if (status.phase_b1) begin
                    cmd.start_copy = 1'b1;
                    state_next     = ST_RD;
                end else if (status.flag_bit) begin
                    state_next = ST_LIT;
                end else begin
                    cmd.store_low = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_LIT: begin
                if (status.out_free) begin
                    cmd.emit_lit = 1'b1;
                    cmd.advance  = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR: begin
                if (status.out_free) begin
                    cmd.emit_copy = 1'b1;
                    if (status.copy_stop) begin
                        cmd.advance = 1'b1;
                        state_next  = ST_FINISH;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pkld_datapath.sv =====
// ----------------------------------------------------------------------------
// pkld_datapath
// Decryption, token registers, 4096-byte history ring, output count and
// output register of the decoder.
// ----------------------------------------------------------------------------
module pkld_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  pkld_pkg::cmd_t    cmd,
    output pkld_pkg::status_t status,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    localparam int AW = pkld_pkg::RING_AW;
    localparam int FW = pkld_pkg::FILL_W;

    logic [7:0] ring_mem [pkld_pkg::RING_DEPTH];

    logic [31:0]   expected_reg;
    logic [31:0]   produced_reg;
    logic [AW-1:0] wp_reg;
    logic [FW-1:0] fill_reg;
    logic [7:0]    flags_reg;
    logic [3:0]    idx_reg;
    logic [1:0]    phase_reg;
    logic [7:0]    pos_reg;
    logic [7:0]    pend_reg;
    logic [AW-1:0] copy_addr_reg;
    logic [4:0]    len_reg;
    logic          out_valid_reg;

    logic [7:0] b_reg;
    logic       last_reg;
    logic [7:0] rd_data_reg;
    logic       rd_hit_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_done_reg;

    logic [31:0]   produced_inc;
    logic          done_now;
    logic          emit;
    logic [7:0]    emit_data;
    logic          emit_last;
    logic [AW-1:0] rd_offset;
    logic [3:0]    idx_inc;

    assign produced_inc = produced_reg + 32'd1;
    assign done_now     = produced_inc >= expected_reg;
    assign emit         = cmd.emit_lit | cmd.emit_copy;
    // Entries not written since the stream began read as the fill byte
    assign rd_offset    = copy_addr_reg - pkld_pkg::START_POS;
    assign idx_inc      = idx_reg + 4'd1;

    always_comb begin
        if (cmd.emit_lit) begin
            emit_data = b_reg;
            emit_last = 1'b1;
        end else begin
            emit_data = rd_hit_reg ? rd_data_reg : pkld_pkg::FILL_BYTE;
            emit_last = status.copy_stop;
        end
    end

    always_comb begin
        status.active    = produced_reg < expected_reg;
        status.want_flag = (phase_reg == pkld_pkg::PH_FLAG) || (phase_reg > pkld_pkg::PH_B1)
                           || (idx_reg >= pkld_pkg::IDX_EMPTY);
        status.phase_b1  = phase_reg == pkld_pkg::PH_B1;
        status.flag_bit  = flags_reg[idx_reg[2:0]];
        status.out_free  = !out_valid_reg || m_tready;
        status.copy_stop = (len_reg == 5'd1) || done_now;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg  <= pkld_pkg::SIZE_RST;
            produced_reg  <= '0;
            wp_reg        <= pkld_pkg::START_POS;
            fill_reg      <= '0;
            flags_reg     <= '0;
            idx_reg       <= pkld_pkg::IDX_EMPTY;
            phase_reg     <= pkld_pkg::PH_FLAG;
            pos_reg       <= '0;
            pend_reg      <= '0;
            copy_addr_reg <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                expected_reg <= cfg_wdata;
            end
            if (cmd.take) begin
                pos_reg <= pos_reg + 8'd1;
            end
            if (cmd.load_flag) begin
                flags_reg <= b_reg;
                idx_reg   <= '0;
                phase_reg <= pkld_pkg::PH_TOK;
            end
            if (cmd.store_low) begin
                pend_reg  <= b_reg;
                phase_reg <= pkld_pkg::PH_B1;
            end
            if (cmd.start_copy) begin
                copy_addr_reg <= {b_reg[7:4], pend_reg};
                len_reg       <= {1'b0, b_reg[3:0]} + pkld_pkg::MIN_LEN;
            end
            if (cmd.rd) begin
                copy_addr_reg <= copy_addr_reg + AW'(1);
            end
            if (cmd.emit_copy) begin
                len_reg <= len_reg - 5'd1;
            end
            if (emit) begin
                wp_reg       <= wp_reg + AW'(1);
                produced_reg <= produced_inc;
                if (fill_reg != FW'(pkld_pkg::RING_DEPTH)) begin
                    fill_reg <= fill_reg + FW'(1);
                end
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.advance) begin
                if (idx_inc >= pkld_pkg::IDX_EMPTY) begin
                    idx_reg   <= pkld_pkg::IDX_EMPTY;
                    phase_reg <= pkld_pkg::PH_FLAG;
                end else begin
                    idx_reg   <= idx_inc;
                    phase_reg <= pkld_pkg::PH_TOK;
                end
            end
            // End of body: reset the stream counters and token state and forget the ring
            if (cmd.finish && last_reg) begin
                produced_reg <= '0;
                wp_reg       <= pkld_pkg::START_POS;
                fill_reg     <= '0;
                flags_reg    <= '0;
                idx_reg      <= pkld_pkg::IDX_EMPTY;
                phase_reg    <= pkld_pkg::PH_FLAG;
                pos_reg      <= '0;
                pend_reg     <= '0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            b_reg    <= s_tdata - pos_reg;
            last_reg <= s_tlast;
        end
        if (emit) begin
            out_data_reg <= emit_data;
            out_last_reg <= emit_last;
            out_done_reg <= done_now;
        end
    end

    // History ring
    always_ff @(posedge aclk) begin
        if (emit) begin
            ring_mem[wp_reg] <= emit_data;
        end
        if (cmd.rd) begin
            rd_data_reg <= ring_mem[copy_addr_reg];
            rd_hit_reg  <= {1'b0, rd_offset} < fill_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule
